// ===== design/tccw_pkg.sv =====
// Shared constants, codes and the cell index helper for the text console writer.
// No dependencies; imported by tccw_ram users and the top level.
package tccw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int COPY_CELLS = (ROWS - 1) * COLUMNS;

  localparam int MODE_W = 2;
  localparam int CHAR_W = 8;
  localparam int ADDR_W = 11;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CELL_W = 16;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [COL_W-1:0]  col_t;
  typedef logic [ROW_W-1:0]  row_t;
  typedef logic [CELL_W-1:0] cell_t;
  typedef logic [CHAR_W-1:0] char_t;

  localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  localparam char_t CH_NEWLINE   = 8'd10;
  localparam char_t CH_BACKSPACE = 8'd8;
  localparam char_t CH_BLANK     = 8'h20;
  localparam char_t ATTR_RESET   = 8'h3F;

  // register index as seen on paddr[2]
  localparam logic CFG_ATTR_IDX = 1'b0;

  function automatic addr_t cell_index(input row_t row, input col_t col);
    addr_t r;
    r = addr_t'(addr_t'(row) * addr_t'(COLUMNS)) + addr_t'(col);
    return r;
  endfunction

endpackage

// ===== design/text_console_char_writer_top.sv =====
// Text console character writer: screen cell RAM, cursor, scroll and clear sequencer.
// Depends on tccw_pkg and tccw_ram.
//
//   port group   dir  beat contents
//   s_t*         in   mode, char_code, cell_address
//   m_t*         out  cursor_col, cursor_row, cursor_offset, cell_value
//   p*           cfg  APB register 0 at 0x0: text attribute byte
//
// Put, newline, unused mode: the result is registered out of the done state; a read first passes
// a read state (registered RAM read). A scroll copies rows 1..ROWS-1 up one row, then blanks the
// last row's COLUMNS cells, all on the single RAM write port. Clear blanks all CELL_COUNT cells.
// After reset the RAM is blanked in a pass over all CELL_COUNT (2000) cells; s_tready stays low.
// One item at a time; a result waiting on m_tready holds off the next one at its last step.
module text_console_char_writer_top
  import tccw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [1:0] mode, [9:2] char_code, [20:10] cell_address
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [6:0] cursor_col, [11:7] cursor_row,
                                 // [22:12] cursor_offset, [38:23] cell_value
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_READ  = 3'd1;
  localparam logic [2:0] ST_COPY  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_FILL  = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0]        state;
  logic              init_pass;
  addr_t             idx;
  addr_t             widx;
  logic              pend;
  cell_t             fill;
  col_t              cur_col;
  row_t              cur_row;
  char_t             attr;
  logic              rd_ok;
  cell_t             value;

  logic [MODE_W-1:0] in_mode;
  char_t             in_char;
  addr_t             in_addr;
  logic              accept;

  col_t              nx_col;
  row_t              nx_row;
  col_t              pos_col;
  row_t              pos_row;
  char_t             put_char;
  logic              put_we;
  logic              scroll;

  logic              we;
  addr_t             waddr;
  cell_t             wdata;
  addr_t             raddr;
  cell_t             rdata;

  assign in_mode  = s_tdata[1:0];
  assign in_char  = s_tdata[9:2];
  assign in_addr  = s_tdata[20:10];
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == CFG_ATTR_IDX) ? {24'b0, attr} : 32'b0;

  // cursor motion for a put
  always_comb begin
    nx_col   = cur_col;
    nx_row   = cur_row;
    pos_col  = cur_col;
    pos_row  = cur_row;
    put_char = in_char;
    put_we   = 1'b0;
    if (in_char == CH_NEWLINE) begin
      nx_col = '0;
      nx_row = cur_row + row_t'(1);
    end else if (in_char == CH_BACKSPACE) begin
      if (cur_col != '0) begin
        nx_col = cur_col - col_t'(1);
      end else if (cur_row != '0) begin
        nx_row = cur_row - row_t'(1);
        nx_col = col_t'(COLUMNS - 1);
      end
      pos_col  = nx_col;
      pos_row  = nx_row;
      put_char = CH_BLANK;
      put_we   = 1'b1;
    end else begin
      put_we = 1'b1;
      if (cur_col == col_t'(COLUMNS - 1)) begin
        nx_col = '0;
        nx_row = cur_row + row_t'(1);
      end else begin
        nx_col = cur_col + col_t'(1);
      end
    end
    scroll = (nx_row == row_t'(ROWS));
  end

  // single write port: pending copy beat, fill sweep, or a put
  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wdata = fill;
    if (pend) begin
      we    = 1'b1;
      waddr = widx;
      wdata = rdata;
    end else if (state == ST_FILL) begin
      we = 1'b1;
    end else if (accept && in_mode == MODE_PUT && put_we) begin
      we    = 1'b1;
      waddr = cell_index(pos_row, pos_col);
      wdata = {attr, put_char};
    end
  end

  always_comb begin
    if (state == ST_COPY) begin
      raddr = idx + addr_t'(COLUMNS);
    end else if (in_addr < addr_t'(CELL_COUNT)) begin
      raddr = in_addr;
    end else begin
      raddr = '0;
    end
  end

  tccw_ram #(
    .DEPTH(CELL_COUNT),
    .WIDTH(CELL_W),
    .AW   (ADDR_W)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_FILL;
      init_pass <= 1'b1;
      idx       <= '0;
      fill      <= {ATTR_RESET, CH_BLANK};
      cur_col   <= '0;
      cur_row   <= '0;
      pend      <= 1'b0;
      m_tvalid  <= 1'b0;
      attr      <= ATTR_RESET;
    end else begin
      // read row below now, write it one row up next cycle
      pend <= (state == ST_COPY);
      widx <= idx;
      if (psel && penable && pwrite && paddr[2] == CFG_ATTR_IDX) begin
        attr <= pwdata[7:0];
      end
      if (m_tvalid && m_tready && state != ST_DONE) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            value <= '0;
            case (in_mode)
              MODE_PUT: begin
                cur_col <= nx_col;
                if (scroll) begin
                  cur_row <= row_t'(ROWS - 1);
                  idx     <= '0;
                  state   <= ST_COPY;
                end else begin
                  cur_row <= nx_row;
                  state   <= ST_DONE;
                end
              end
              MODE_READ: begin
                rd_ok <= (in_addr < addr_t'(CELL_COUNT));
                state <= ST_READ;
              end
              MODE_CLEAR: begin
                cur_col <= '0;
                cur_row <= '0;
                idx     <= '0;
                fill    <= {attr, CH_BLANK};
                state   <= ST_FILL;
              end
              default: state <= ST_DONE;
            endcase
          end
        end
        ST_READ: begin
          value <= rd_ok ? rdata : '0;
          state <= ST_DONE;
        end
        ST_COPY: begin
          if (idx == addr_t'(COPY_CELLS - 1)) begin
            state <= ST_DRAIN;
          end else begin
            idx <= idx + addr_t'(1);
          end
        end
        ST_DRAIN: begin
          idx   <= addr_t'(COPY_CELLS);
          fill  <= {attr, CH_BLANK};
          state <= ST_FILL;
        end
        ST_FILL: begin
          if (idx == addr_t'(CELL_COUNT - 1)) begin
            state     <= init_pass ? ST_IDLE : ST_DONE;
            init_pass <= 1'b0;
          end else begin
            idx <= idx + addr_t'(1);
          end
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {1'b0, value, cell_index(cur_row, cur_col), cur_row, cur_col};
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while an item is in flight");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (cur_row < row_t'(ROWS)) && (cur_col < col_t'(COLUMNS)))
    else $error("cursor outside the screen");

  a_pend_in_copy: assert property (@(posedge clk) disable iff (rst)
    pend |-> (state == ST_COPY || state == ST_DRAIN))
    else $error("copy write outside the scroll sequence");

  a_init_blocks_input: assert property (@(posedge clk) disable iff (rst)
    init_pass |-> !s_tready)
    else $error("input taken during the reset blanking pass");
`endif

endmodule

// ===== design/tccw_ram.sv =====
// Simple dual-port synchronous RAM: one write port, one read port, registered read data.
// Generic; no package dependency.
module tccw_ram #(
  parameter int DEPTH = 2000,
  parameter int WIDTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== tb/sv/text_console_char_writer_top_tb.sv =====
// Self-checking bench for the text console writer: a queue-fed stream driver, a
// response monitor and a cycle-free screen/cursor predictor checked beat by beat.
// Depends on tccw_pkg and text_console_char_writer_top.
module text_console_char_writer_top_tb
  import tccw_pkg::*;
;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int  PHASES         = 5;
  localparam int  PHASE_ITEMS    = 226;
  localparam int  LONG_HOLD      = 400;
  localparam int  DRAIN_CYCLES   = 50;
  localparam longint TIMEOUT_CYCLES = 10_000_000;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    char_t             ch;
    addr_t             addr;
  } console_op_t;

  typedef struct packed {
    col_t  col;
    row_t  row;
    addr_t offset;
    cell_t value;
  } cursor_report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;  // [1:0] mode, [9:2] char_code, [20:10] cell_address
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;       // [6:0] cursor_col, [11:7] cursor_row,
                              // [22:12] cursor_offset, [38:23] cell_value
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  text_console_char_writer_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // shadow of the screen, cursor and color register
  cell_t shadow_cells [CELL_COUNT];
  int    shadow_col;
  int    shadow_row;
  char_t shadow_attr;

  console_op_t    op_backlog[$];
  cursor_report_t cursor_reports[$];
  int             mismatch_count = 0;
  int             queued_count = 0;
  int             checked_count = 0;

  logic in_taken  = 1'b0;
  logic out_taken = 1'b0;
  int   gap_left  = 0;
  int   sent_count = 0;
  logic tx_burst  = 1'b0;
  int   wait_left = 0;
  int   stall_left = 0;
  int   beat_count = 0;
  logic rx_burst  = 1'b0;
  int   hold_asked = 0;
  int   hold_done  = 0;

  function automatic void blank_screen();
    for (int i = 0; i < CELL_COUNT; i++) shadow_cells[i] = {shadow_attr, CH_BLANK};
    shadow_col = 0;
    shadow_row = 0;
  endfunction

  function automatic void place_char(char_t ch);
    if (ch == CH_NEWLINE) begin
      shadow_col = 0;
      shadow_row++;
    end else if (ch == CH_BACKSPACE) begin
      if (shadow_col > 0) begin
        shadow_col--;
      end else if (shadow_row > 0) begin
        shadow_row--;
        shadow_col = COLUMNS - 1;
      end
      shadow_cells[shadow_row * COLUMNS + shadow_col] = {shadow_attr, CH_BLANK};
    end else begin
      shadow_cells[shadow_row * COLUMNS + shadow_col] = {shadow_attr, ch};
      shadow_col++;
      if (shadow_col >= COLUMNS) begin
        shadow_col = 0;
        shadow_row++;
      end
    end
    // ran off the bottom: scroll up one row
    if (shadow_row >= ROWS) begin
      for (int i = 0; i < COPY_CELLS; i++) shadow_cells[i] = shadow_cells[i + COLUMNS];
      for (int c = 0; c < COLUMNS; c++) shadow_cells[COPY_CELLS + c] = {shadow_attr, CH_BLANK};
      shadow_row = ROWS - 1;
    end
  endfunction

  function automatic cursor_report_t apply_console_op(console_op_t op);
    cursor_report_t rep;
    rep.value = '0;
    case (op.mode)
      MODE_PUT:   place_char(op.ch);
      MODE_READ:  if (op.addr < CELL_COUNT) rep.value = shadow_cells[op.addr];
      MODE_CLEAR: blank_screen();
      default: ;
    endcase
    rep.col    = col_t'(shadow_col);
    rep.row    = row_t'(shadow_row);
    rep.offset = addr_t'(shadow_row * COLUMNS + shadow_col);
    return rep;
  endfunction

  function automatic console_op_t random_op(int nl_pct, int clr_pct);
    console_op_t op;
    int          r;
    op.ch   = char_t'($urandom_range(0, 255));
    op.addr = addr_t'($urandom_range(0, CELL_COUNT - 1));
    r = $urandom_range(0, 99);
    if (r < clr_pct) begin
      op.mode = MODE_CLEAR;
    end else if (r < clr_pct + 3) begin
      op.mode = MODE_UNUSED;
      op.addr = addr_t'($urandom_range(0, 2047));
    end else if (r < clr_pct + 25) begin
      op.mode = MODE_READ;
      if ($urandom_range(0, 99) < 15) op.addr = addr_t'($urandom_range(0, 2047));
    end else begin
      op.mode = MODE_PUT;
      r = $urandom_range(0, 99);
      if (r < nl_pct) op.ch = CH_NEWLINE;
      else if (r < nl_pct + 8) op.ch = CH_BACKSPACE;
    end
    return op;
  endfunction

  function automatic void queue_op(logic [MODE_W-1:0] mode, char_t ch, addr_t addr);
    console_op_t op;
    op.mode = mode;
    op.ch   = ch;
    op.addr = addr;
    op_backlog.push_back(op);
    queued_count++;
  endfunction

  // every queued item has been answered
  task automatic wait_idle();
    while (checked_count != queued_count)
      @(negedge clk);
  endtask

  task automatic write_attr(char_t value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {CFG_ATTR_IDX, 2'b00};
    pwdata  <= 32'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    shadow_attr = value;
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_CYCLES * 10);
    $display("Verification failed");
    $finish;
  end

  // input beat driver
  always @(negedge clk) begin
    console_op_t op;
    logic        valid_next;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_taken) begin
      valid_next = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (op_backlog.size() > 0) begin
        op = op_backlog.pop_front();
        s_tdata <= {3'b000, op.addr, op.ch, op.mode};
        valid_next = 1'b1;
        sent_count++;
        if (sent_count % 48 == 0) tx_burst = ($urandom_range(0, 3) == 0);
        gap_left = tx_burst ? 0 : $urandom_range(0, 4);
      end
      s_tvalid <= valid_next;
    end
  end

  // output ready: per-beat waits plus a long hold when the test asks for one
  always @(negedge clk) begin
    logic rdy;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (out_taken) begin
        beat_count++;
        if (beat_count % 48 == 0) rx_burst = ($urandom_range(0, 3) == 0);
        wait_left = rx_burst ? 0 : $urandom_range(0, 4);
      end
      if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else if (hold_done != hold_asked) begin
        hold_done  = hold_asked;
        stall_left = LONG_HOLD - 1;
        rdy = 1'b0;
      end else if (wait_left > 0) begin
        wait_left--;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      m_tready <= rdy;
    end
  end

  // monitor: outputs are checked before the same edge's input is predicted
  always @(posedge clk) begin
    cursor_report_t want;
    console_op_t    op;
    if (rst) begin
      in_taken  <= 1'b0;
      out_taken <= 1'b0;
    end else begin
      in_taken  <= s_tvalid && s_tready;
      out_taken <= m_tvalid && m_tready;
      if (m_tvalid && m_tready) begin
        if (cursor_reports.size() == 0) begin
          $error("unexpected output beat: %h", m_tdata);
          mismatch_count++;
        end else begin
          want = cursor_reports.pop_front();
          checked_count++;
          if (m_tdata[6:0] !== want.col) begin
            $error("cursor_col: expected %0d, got %0d", want.col, m_tdata[6:0]);
            mismatch_count++;
          end
          if (m_tdata[11:7] !== want.row) begin
            $error("cursor_row: expected %0d, got %0d", want.row, m_tdata[11:7]);
            mismatch_count++;
          end
          if (m_tdata[22:12] !== want.offset) begin
            $error("cursor_offset: expected %0d, got %0d", want.offset, m_tdata[22:12]);
            mismatch_count++;
          end
          if (m_tdata[38:23] !== want.value) begin
            $error("cell_value: expected %h, got %h", want.value, m_tdata[38:23]);
            mismatch_count++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        op.mode = s_tdata[1:0];
        op.ch   = s_tdata[9:2];
        op.addr = s_tdata[20:10];
        cursor_reports.push_back(apply_console_op(op));
      end
    end
  end

  initial begin
    int nl_pct [PHASES];
    int clr_pct [PHASES];
    nl_pct  = '{6, 35, 3, 35, 8};
    clr_pct = '{3, 1, 0, 1, 3};
    shadow_attr = ATTR_RESET;
    blank_screen();
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // directed: reset contents, screen edges, odd bytes, backspace wraps, unused mode
    queue_op(MODE_READ, 8'h00, 11'd0);
    queue_op(MODE_READ, 8'hFF, 11'd1999);
    queue_op(MODE_READ, 8'h00, 11'd2000);
    queue_op(MODE_READ, 8'h00, 11'd2047);
    queue_op(MODE_PUT, CH_BACKSPACE, 11'd0);
    queue_op(MODE_PUT, 8'h41, 11'd0);
    queue_op(MODE_PUT, 8'h00, 11'd0);
    queue_op(MODE_PUT, 8'hFF, 11'h7FF);
    queue_op(MODE_READ, 8'h00, 11'd0);
    queue_op(MODE_READ, 8'h00, 11'd1);
    queue_op(MODE_READ, 8'h00, 11'd2);
    queue_op(MODE_PUT, CH_BACKSPACE, 11'd0);
    queue_op(MODE_READ, 8'h00, 11'd2);
    queue_op(MODE_PUT, CH_NEWLINE, 11'd0);
    queue_op(MODE_PUT, CH_BACKSPACE, 11'd0);
    queue_op(MODE_READ, 8'h00, 11'd79);
    queue_op(MODE_UNUSED, 8'hFF, 11'h7FF);
    queue_op(MODE_UNUSED, 8'h00, 11'd0);
    queue_op(MODE_CLEAR, 8'hFF, 11'h7FF);
    queue_op(MODE_READ, 8'h00, 11'd1);
    wait_idle();

    for (int p = 0; p < PHASES; p++) begin
      repeat (4) @(negedge clk);
      case (p)
        0:       write_attr(8'h00);
        1:       write_attr(8'hFF);
        default: write_attr(char_t'($urandom_range(0, 255)));
      endcase
      // a clear right after the write so the new color fills the screen
      if (p == 3) queue_op(MODE_CLEAR, 8'h00, 11'd0);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        op_backlog.push_back(random_op(nl_pct[p], clr_pct[p]));
        queued_count++;
      end
      if (p == 1) hold_asked++;
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
